// ----- rtl/ipid_pkg.sv -----
// ----------------------------------------------------------------------------
// ipid_pkg
// shared constants, register codes and control types of the integer pid
// ----------------------------------------------------------------------------
`default_nettype none

package ipid_pkg;

  localparam int LIMIT_BITS = 10;
  localparam int ISHIFT     = 10;
  localparam int TL_W       = LIMIT_BITS + 2;

  localparam logic [31:0] LIMIT_VAL = 32'(1) << LIMIT_BITS;
  localparam logic [31:0] NEG_LIMIT = 32'(0) - LIMIT_VAL;

  typedef enum logic [2:0] {
    REG_P_GAIN    = 3'd0,
    REG_I_GAIN    = 3'd1,
    REG_D_GAIN    = 3'd2,
    REG_OUT_MIN   = 3'd3,
    REG_OUT_RANGE = 3'd4,
    REG_DERIV_MEAS = 3'd5,
    REG_RUNNING   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic load;
    logic prop;
    logic deriv;
    logic integ;
    logic addi;
    logic clamp;
    logic scale;
    logic finish;
  } ipid_cmd_t;

  typedef struct packed {
    logic running;
  } ipid_sts_t;

endpackage

`default_nettype wire

// ----- rtl/ipid_ctrl.sv -----
// ----------------------------------------------------------------------------
// ipid_ctrl
// sequencer of one control tick through the shared multiplier datapath
// ----------------------------------------------------------------------------
`default_nettype none

module ipid_ctrl import ipid_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      tick_valid,
  output logic           tick_stall,
  output logic           result_valid,
  input  wire logic      result_stall,
  input  wire ipid_sts_t sts,
  output ipid_cmd_t      cmd
);

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_PROP  = 8'b0000_0010,
    S_DERIV = 8'b0000_0100,
    S_INTEG = 8'b0000_1000,
    S_ADDI  = 8'b0001_0000,
    S_CLAMP = 8'b0010_0000,
    S_SCALE = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  state_t state, state_next;
  logic   result_valid_next;
  logic   out_free;

  assign out_free   = !result_valid || !result_stall;
  assign tick_stall = (state != S_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      S_IDLE: begin
        cmd.load = tick_valid;
        if (tick_valid && sts.running) begin
          state_next = S_PROP;
        end
      end
      S_PROP: begin
        cmd.prop   = 1'b1;
        state_next = S_DERIV;
      end
      S_DERIV: begin
        cmd.deriv  = 1'b1;
        state_next = S_INTEG;
      end
      S_INTEG: begin
        cmd.integ  = 1'b1;
        state_next = S_ADDI;
      end
      S_ADDI: begin
        cmd.addi   = 1'b1;
        state_next = S_CLAMP;
      end
      S_CLAMP: begin
        cmd.clamp  = 1'b1;
        state_next = S_SCALE;
      end
      S_SCALE: begin
        cmd.scale  = 1'b1;
        state_next = S_OUT;
      end
      S_OUT: begin
        cmd.finish = out_free;
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_comb begin
    result_valid_next = result_valid;
    if (cmd.finish) begin
      result_valid_next = 1'b1;
    end else if (result_valid && !result_stall) begin
      result_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      result_valid <= 1'b0;
    end else begin
      state        <= state_next;
      result_valid <= result_valid_next;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/ipid_dpath.sv -----
// ----------------------------------------------------------------------------
// ipid_dpath
// gain registers, controller history and shared multiplier datapath
// ----------------------------------------------------------------------------
`default_nettype none

module ipid_dpath import ipid_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_wr,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data,
  input  wire logic signed [31:0] target_value,
  input  wire logic signed [31:0] measured_value,
  input  wire ipid_cmd_t          cmd,
  output ipid_sts_t               sts,
  output logic signed [17:0]      drive,
  output logic                    at_target,
  output logic                    clamped_high,
  output logic                    clamped_low
);

  logic signed [15:0] p_gain, i_gain, d_gain, output_min;
  logic        [15:0] output_range;
  logic               deriv_meas;
  logic               running;

  logic [31:0] acc, prev_err, prev_meas;
  logic        lim_hi, lim_lo;

  logic [31:0]     err, meas, diff, prod, total;
  logic [TL_W-1:0] tl;
  logic            sub;

  logic signed [16:0] mul_a;
  logic signed [31:0] mul_b;
  logic signed [48:0] mul_full;
  logic               hold;
  logic               hi, lo;
  logic [31:0]        clamped, tl_full, scaled;

  assign sts.running = running;

  always_comb begin
    if (cmd.prop) begin
      mul_a = {p_gain[15], p_gain};
      mul_b = $signed(err);
    end else if (cmd.deriv) begin
      mul_a = {d_gain[15], d_gain};
      mul_b = $signed(diff);
    end else if (cmd.integ) begin
      mul_a = {i_gain[15], i_gain};
      mul_b = $signed(acc);
    end else begin
      mul_a = $signed({1'b0, output_range});
      mul_b = $signed({{(32 - TL_W){1'b0}}, tl});
    end
  end

  assign mul_full = mul_a * mul_b;

  assign hold = (lim_hi && $signed(err) > 0) || (lim_lo && $signed(err) < 0);

  assign hi      = $signed(total) > $signed(LIMIT_VAL);
  assign lo      = $signed(total) < $signed(NEG_LIMIT);
  assign clamped = hi ? LIMIT_VAL : (lo ? NEG_LIMIT : total);
  assign tl_full = clamped + LIMIT_VAL;

  assign scaled = 32'($signed(prod) >>> (LIMIT_BITS + 1)) + 32'($signed(output_min));

  // configuration and controller history
  always_ff @(posedge clk) begin
    if (rst) begin
      p_gain       <= '0;
      i_gain       <= '0;
      d_gain       <= '0;
      output_min   <= '0;
      output_range <= '0;
      deriv_meas   <= 1'b1;
      running      <= 1'b0;
      acc          <= '0;
      prev_err     <= '0;
      prev_meas    <= '0;
      lim_hi       <= 1'b0;
      lim_lo       <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (cfg_reg_t'(cfg_index))
          REG_P_GAIN:     p_gain       <= cfg_data;
          REG_I_GAIN:     i_gain       <= cfg_data;
          REG_D_GAIN:     d_gain       <= cfg_data;
          REG_OUT_MIN:    output_min   <= cfg_data;
          REG_OUT_RANGE:  output_range <= cfg_data;
          REG_DERIV_MEAS: deriv_meas   <= cfg_data[0];
          REG_RUNNING:    running      <= cfg_data[0];
          default: begin
          end
        endcase
      end
      if (cmd.prop) begin
        if (!hold) begin
          acc <= acc + err;
        end
        if (deriv_meas) begin
          prev_meas <= meas;
        end else begin
          prev_err <= err;
        end
      end
      if (cmd.clamp) begin
        lim_hi <= hi;
        lim_lo <= lo;
      end
    end
  end

  // per-tick working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      err  <= target_value - measured_value;
      meas <= measured_value;
    end
    if (cmd.prop) begin
      diff <= deriv_meas ? (meas - prev_meas) : (err - prev_err);
      sub  <= deriv_meas;
    end
    if (cmd.prop || cmd.deriv || cmd.integ || cmd.scale) begin
      prod <= mul_full[31:0];
    end
    if (cmd.deriv) begin
      total <= prod;
    end
    if (cmd.integ) begin
      total <= sub ? (total - prod) : (total + prod);
    end
    if (cmd.addi) begin
      total <= total + 32'($signed(prod) >>> ISHIFT);
    end
    if (cmd.clamp) begin
      tl <= tl_full[TL_W-1:0];
    end
    if (cmd.finish) begin
      drive        <= $signed(scaled[17:0]);
      at_target    <= (err == '0);
      clamped_high <= lim_hi;
      clamped_low  <= lim_lo;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/integer_pid_controller_top.sv -----
// ----------------------------------------------------------------------------
// integer_pid_controller_top
// integer pid controller with anti-windup and scaled, clamped drive output
// ----------------------------------------------------------------------------
// Usage:
//   tick channel (tick_valid / tick_stall) carries target_value and
//   measured_value; a transfer happens when valid is high and stall low.
//   result channel (result_valid / result_stall) carries drive, at_target,
//   clamped_high and clamped_low.
//   cfg channel (cfg_valid / cfg_ready, cfg_index, cfg_data) writes the
//   gain, scaling, mode and run registers; cfg_ready is always high and
//   writes are to be made while no tick is in flight; the block does not enforce this.
//   While running, a tick runs from its transfer to result_valid through
//   the one shared 17x32 multiplier used for the p, d, i and scaling
//   products, and a new tick is taken only once that result is set.
//   When stopped, ticks are taken every cycle and give no result.
//   A stalled result holds in the output register; the next tick is taken
//   meanwhile and waits in its last step until the result is transferred.
//   Reset clears history, gains and flags, selects derivative on
//   measurement and stops the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module integer_pid_controller_top import ipid_pkg::*; (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               tick_valid,
  output logic                    tick_stall,
  input  wire logic signed [31:0] target_value,
  input  wire logic signed [31:0] measured_value,
  output logic                    result_valid,
  input  wire logic               result_stall,
  output logic signed [17:0]      drive,
  output logic                    at_target,
  output logic                    clamped_high,
  output logic                    clamped_low,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [2:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);

  ipid_cmd_t cmd;
  ipid_sts_t sts;

  assign cfg_ready = 1'b1;

  ipid_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .tick_valid   (tick_valid),
    .tick_stall   (tick_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  ipid_dpath u_dpath (
    .clk            (clk),
    .rst            (rst),
    .cfg_wr         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .target_value   (target_value),
    .measured_value (measured_value),
    .cmd            (cmd),
    .sts            (sts),
    .drive          (drive),
    .at_target      (at_target),
    .clamped_high   (clamped_high),
    .clamped_low    (clamped_low)
  );

  a_busy_after_tick: assert property (@(posedge clk) disable iff (rst)
    (tick_valid && !tick_stall && sts.running) |=> tick_stall)
    else $error("running tick transfer did not start a computation");

  a_prop_then_deriv: assert property (@(posedge clk) disable iff (rst)
    cmd.prop |=> cmd.deriv)
    else $error("derivative step did not follow proportional step");

  a_clamp_exclusive: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> !(clamped_high && clamped_low))
    else $error("both clamp flags set on one result");

endmodule

`default_nettype wire
